// ===== design/dspe_pkg.sv =====
package dspe_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned VERTEX_FIELD_W = 4;
  localparam int unsigned WEIGHT_FIELD_W = 16;
  localparam int unsigned DIST_FIELD_W   = 20;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned COUNT_REG_W = 5;
  localparam int unsigned SOURCE_REG_W = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_VERTEX = 2'd1;

  localparam logic [COUNT_REG_W-1:0]  VERTEX_COUNT_RESET  = 5'd16;
  localparam logic [SOURCE_REG_W-1:0] SOURCE_VERTEX_RESET = 4'd0;

  // Input operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mat_wr;       // write one matrix entry from the input beat
    logic start;        // a run begins: clear the unsettled set
    logic rd_init;      // read source row entry at the current index
    logic rd_relax;     // read settled row entry and distance at the index
    logic settle;       // settle the best vertex found in the last pass
    logic rd_out;       // read distance at the index for reporting
    logic load_out;     // load the output register
    logic out_last;     // the loaded result closes the run
    logic out_unreach;  // report the loaded result as unreachable
  } dspe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;     // an unsettled vertex was seen in the last pass
    logic out_free;  // the output register can take a result this cycle
  } dspe_stat_t;

endpackage

// ===== design/dense_shortest_path_engine.sv =====
// Channel   Direction  Handshake             Beat contents
// in        receive    in_valid_i/in_stall_o operation, from/to vertex, weight, no_edge
// out       send       out_valid_o/out_stall_i vertex, distance, reachable, last
// cfg       receive    cfg_valid_i/cfg_ready_o register index, write data
//
// A run over n vertices loads the source row, then makes a pass over the n
// vertices for each further settled vertex (one matrix and distance read per
// cycle), and then reports each result in turn; the single read port of each
// memory sets this pace. Reset clears the control state and sets the
// configuration to its defaults; the matrix holds no defined value until
// written. A stalled output holds its beat and the run waits for it; no input
// beat is taken until the run's last result is loaded.
module dense_shortest_path_engine #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16,
  parameter int unsigned DIST_BITS    = 20
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    operation_i,
  input  logic [dspe_pkg::VERTEX_FIELD_W-1:0]     from_vertex_i,
  input  logic [dspe_pkg::VERTEX_FIELD_W-1:0]     to_vertex_i,
  input  logic [dspe_pkg::WEIGHT_FIELD_W-1:0]     edge_weight_i,
  input  logic                                    no_edge_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [dspe_pkg::VERTEX_FIELD_W-1:0]     vertex_o,
  output logic [dspe_pkg::DIST_FIELD_W-1:0]       distance_o,
  output logic                                    reachable_o,
  output logic                                    last_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dspe_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [dspe_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);

  dspe_pkg::dspe_cmd_t  cmd;
  dspe_pkg::dspe_stat_t stat;
  logic [VW-1:0]        idx;
  logic [VW-1:0]        src;

  // Sequencer and configuration registers.
  dspe_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .idx_o         (idx),
    .src_o         (src)
  );

  // Memories, relaxation arithmetic and output register.
  dspe_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .DIST_BITS    (DIST_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .idx_i         (idx),
    .src_i         (src),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .edge_weight_i (edge_weight_i),
    .no_edge_i     (no_edge_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vertex_o      (vertex_o),
    .distance_o    (distance_o),
    .reachable_o   (reachable_o),
    .last_o        (last_o)
  );

endmodule

// ===== design/dspe_ctrl.sv =====
module dspe_ctrl #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    operation_i,
  input  logic [dspe_pkg::VERTEX_FIELD_W-1:0]     from_vertex_i,
  input  logic [dspe_pkg::VERTEX_FIELD_W-1:0]     to_vertex_i,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dspe_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [dspe_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  dspe_pkg::dspe_stat_t                    stat_i,
  output dspe_pkg::dspe_cmd_t                     cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]         idx_o,
  output logic [$clog2(MAX_VERTICES)-1:0]         src_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INIT   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_SETTLE = 7'b0001000,
    S_RELAX  = 7'b0010000,
    S_ORD    = 7'b0100000,
    S_OLOAD  = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [VW-1:0] idx_q, idx_d;
  logic unreach_q, unreach_d;
  logic [dspe_pkg::COUNT_REG_W-1:0]  vcount_q;
  logic [dspe_pkg::SOURCE_REG_W-1:0] source_q;
  logic [NW-1:0] n_eff;
  logic idx_last;
  logic src_ok;
  logic accept;
  logic wr_in_range;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= dspe_pkg::VERTEX_COUNT_RESET;
      source_q <= dspe_pkg::SOURCE_VERTEX_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dspe_pkg::CFG_VERTEX_COUNT: begin
          vcount_q <= cfg_data_i[dspe_pkg::COUNT_REG_W-1:0];
        end
        dspe_pkg::CFG_SOURCE_VERTEX: begin
          source_q <= cfg_data_i[dspe_pkg::SOURCE_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective vertex count: zero acts as one, large values clamp.
  always_comb begin
    if (vcount_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_q);
    end
  end

  assign idx_last    = (32'(idx_q) + 32'd1) == 32'(n_eff);
  assign src_ok      = 32'(source_q) < 32'(n_eff);
  assign src_o       = VW'(source_q);
  assign idx_o       = idx_q;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign wr_in_range = (32'(from_vertex_i) < MAX_VERTICES) &&
                       (32'(to_vertex_i) < MAX_VERTICES);

  // Sequencer: load source row, then one relaxation pass per settled vertex,
  // then stream the distances out; a source beyond the vertex count goes straight to streaming.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    unreach_d = unreach_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == dspe_pkg::OP_RUN) begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            unreach_d   = !src_ok;
            state_d     = src_ok ? S_INIT : S_ORD;
          end else begin
            cmd_o.mat_wr = wr_in_range;
          end
        end
      end
      S_INIT: begin
        cmd_o.rd_init = 1'b1;
        if (idx_last) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end
      S_RELAX: begin
        cmd_o.rd_relax = 1'b1;
        if (idx_last) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        idx_d = '0;
        if (stat_i.found) begin
          cmd_o.settle = 1'b1;
          state_d      = S_RELAX;
        end else begin
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        cmd_o.rd_out = 1'b1;
        state_d      = S_OLOAD;
      end
      S_OLOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out    = 1'b1;
          cmd_o.out_last    = idx_last;
          cmd_o.out_unreach = unreach_q;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + VW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      unreach_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      unreach_q <= unreach_d;
    end
  end

endmodule

// ===== design/dspe_datapath.sv =====
module dspe_datapath #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16,
  parameter int unsigned DIST_BITS    = 20
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dspe_pkg::dspe_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]         idx_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]         src_i,
  input  logic [dspe_pkg::VERTEX_FIELD_W-1:0]     from_vertex_i,
  input  logic [dspe_pkg::VERTEX_FIELD_W-1:0]     to_vertex_i,
  input  logic [dspe_pkg::WEIGHT_FIELD_W-1:0]     edge_weight_i,
  input  logic                                    no_edge_i,
  output dspe_pkg::dspe_stat_t                    stat_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [dspe_pkg::VERTEX_FIELD_W-1:0]     vertex_o,
  output logic [dspe_pkg::DIST_FIELD_W-1:0]       distance_o,
  output logic                                    reachable_o,
  output logic                                    last_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned EW  = WEIGHT_BITS + 1;
  localparam int unsigned DW  = DIST_BITS + 1;
  localparam int unsigned SW  = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
  localparam int unsigned VFW = dspe_pkg::VERTEX_FIELD_W;
  localparam int unsigned DFW = dspe_pkg::DIST_FIELD_W;

  localparam logic [DIST_BITS-1:0] D_MAX = '1;
  localparam logic [DW-1:0]        D_INF = {1'b1, {DIST_BITS{1'b0}}};

  // Matrix entry to distance, with the absent mark as infinite.
  function automatic logic [DW-1:0] edge_as_dist(input logic [EW-1:0] e);
    logic [SW-1:0] w;
    logic [DW-1:0] r;
    w = SW'(e[WEIGHT_BITS-1:0]);
    if (e[WEIGHT_BITS]) begin
      r = D_INF;
    end else if (w > SW'(D_MAX)) begin
      r = {1'b0, D_MAX};
    end else begin
      r = DW'(w);
    end
    return r;
  endfunction

  // Distance plus edge weight, infinite-absorbing and saturating.
  function automatic logic [DW-1:0] dist_add(input logic [DW-1:0] d, input logic [EW-1:0] e);
    logic [SW-1:0] s;
    logic [DW-1:0] r;
    s = SW'(d[DIST_BITS-1:0]) + SW'(e[WEIGHT_BITS-1:0]);
    if (d[DIST_BITS] || e[WEIGHT_BITS]) begin
      r = D_INF;
    end else if (s > SW'(D_MAX)) begin
      r = {1'b0, D_MAX};
    end else begin
      r = DW'(s);
    end
    return r;
  endfunction

  // Strict order with infinity above every finite value.
  function automatic logic dist_less(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic r;
    if (a[DIST_BITS]) begin
      r = 1'b0;
    end else if (b[DIST_BITS]) begin
      r = 1'b1;
    end else begin
      r = a < b;
    end
    return r;
  endfunction

  logic [EW-1:0] mat_mem [MAX_VERTICES][MAX_VERTICES];
  logic [DW-1:0] dist_mem [MAX_VERTICES];
  logic [EW-1:0] mat_rd_q;
  logic [DW-1:0] dist_rd_q;
  logic [VW-1:0] wr_row, wr_col, rd_row;
  logic [EW-1:0] wr_entry;
  logic          mat_rd_en, dist_rd_en;

  logic          s1_init_q, s1_relax_q;
  logic [VW-1:0] s1_idx_q;
  logic [DW-1:0] new_dist, cand;
  logic          dist_we, consider, better;

  logic [MAX_VERTICES-1:0] mask_q, mask_d;
  logic                    best_valid_q, best_valid_d;
  logic [VW-1:0]           best_idx_q;
  logic [DW-1:0]           best_val_q;
  logic [VW-1:0]           c_q;
  logic [DW-1:0]           dc_q;

  logic                    out_valid_q;
  logic [VFW-1:0]          vertex_q;
  logic [DFW-1:0]          distance_q;
  logic                    reach_q, last_q, reach_now;

  // Edge matrix: one write port for loads, one registered read port.
  assign wr_row    = VW'(from_vertex_i);
  assign wr_col    = VW'(to_vertex_i);
  assign wr_entry  = no_edge_i ? {1'b1, {WEIGHT_BITS{1'b0}}}
                               : {1'b0, WEIGHT_BITS'(edge_weight_i)};
  assign rd_row    = cmd_i.rd_init ? src_i : c_q;
  assign mat_rd_en = cmd_i.rd_init | cmd_i.rd_relax;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_wr) begin
      mat_mem[wr_row][wr_col] <= wr_entry;
    end
    if (mat_rd_en) begin
      mat_rd_q <= mat_mem[rd_row][idx_i];
    end
  end

  // Distance table: written by the update stage, read one index a cycle.
  assign dist_rd_en = cmd_i.rd_relax | cmd_i.rd_out;

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[s1_idx_q] <= new_dist;
    end
    if (dist_rd_en) begin
      dist_rd_q <= dist_mem[idx_i];
    end
  end

  // Update stage tracking: which kind of read returns this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_init_q  <= 1'b0;
      s1_relax_q <= 1'b0;
    end else begin
      s1_init_q  <= cmd_i.rd_init;
      s1_relax_q <= cmd_i.rd_relax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_rd_en) begin
      s1_idx_q <= idx_i;
    end
  end

  // Initial load or relaxation of one vertex, and the running minimum.
  assign cand = dist_add(dc_q, mat_rd_q);

  always_comb begin
    new_dist = dist_rd_q;
    dist_we  = 1'b0;
    consider = 1'b0;
    if (s1_init_q) begin
      new_dist = edge_as_dist(mat_rd_q);
      dist_we  = 1'b1;
      consider = (s1_idx_q != src_i);
    end else if (s1_relax_q && mask_q[s1_idx_q]) begin
      new_dist = dist_less(cand, dist_rd_q) ? cand : dist_rd_q;
      dist_we  = 1'b1;
      consider = 1'b1;
    end
    better = consider && (!best_valid_q || dist_less(new_dist, best_val_q));
  end

  // Unsettled set and best-candidate bookkeeping.
  always_comb begin
    mask_d       = mask_q;
    best_valid_d = best_valid_q;
    if (cmd_i.start) begin
      mask_d       = '0;
      best_valid_d = 1'b0;
    end else if (cmd_i.settle) begin
      mask_d[best_idx_q] = 1'b0;
      best_valid_d       = 1'b0;
    end else begin
      if (s1_init_q && consider) begin
        mask_d[s1_idx_q] = 1'b1;
      end
      if (better) begin
        best_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      best_valid_q <= 1'b0;
    end else begin
      mask_q       <= mask_d;
      best_valid_q <= best_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_idx_q <= s1_idx_q;
      best_val_q <= new_dist;
    end
    if (cmd_i.settle) begin
      c_q  <= best_idx_q;
      dc_q <= best_val_q;
    end
  end

  // Output register: a result waits here while the next one is fetched.
  assign reach_now = !cmd_i.out_unreach && !dist_rd_q[DIST_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      vertex_q   <= VFW'(idx_i);
      distance_q <= reach_now ? DFW'(dist_rd_q[DIST_BITS-1:0]) : '0;
      reach_q    <= reach_now;
      last_q     <= cmd_i.out_last;
    end
  end

  assign stat_o.found    = best_valid_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign distance_o  = distance_q;
  assign reachable_o = reach_q;
  assign last_o      = last_q;

endmodule
